### hw/rtl/grc_pkg.sv
package grc_pkg;

    localparam int RPM_W      = 14;
    localparam int SPEED_W    = 8;
    localparam int K_W        = 16;
    localparam int BOUND_W    = 16;
    localparam int BOUNDS_W   = 2 * BOUND_W;
    localparam int SCALE_W    = SPEED_W + K_W;
    localparam int PROD_W     = BOUND_W + SCALE_W;
    localparam int FRAC_W     = 16;
    localparam int GEAR_W     = 3;
    localparam int GIDX_W     = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int NUM_BOUND_REGS = 5;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_K     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CREEP = 4'd7;

    localparam logic [BOUNDS_W-1:0] BOUND_RESET [NUM_BOUND_REGS] = '{
        32'd369105408, 32'd201330176, 32'd134220160, 32'd97322701, 32'd80545152
    };
    localparam logic [K_W-1:0]     K_RESET     = 16'd1313;
    localparam logic [RPM_W-1:0]   IDLE_RESET  = 14'd800;
    localparam logic [SPEED_W-1:0] CREEP_RESET = 8'd5;

    localparam logic [GEAR_W-1:0] GEAR_NONE = 3'd0;

    typedef struct packed {
        logic [K_W-1:0]     k;
        logic [RPM_W-1:0]   idle_rpm;
        logic [SPEED_W-1:0] creep_speed;
    } grc_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LO,
        ST_HI,
        ST_CHK,
        ST_FINISH
    } grc_state_t;

    typedef struct packed {
        logic               mul_en;
        logic [BOUND_W-1:0] mul_a;
        logic [SCALE_W-1:0] mul_b;
    } grc_mul_ctrl_t;

endpackage

### hw/rtl/grc_ifs.sv
interface grc_in_if;
    import grc_pkg::*;
    logic               valid;
    logic               ready;
    logic [RPM_W-1:0]   engine_rpm;
    logic [SPEED_W-1:0] road_speed;
    modport source (output valid, output engine_rpm, output road_speed, input ready);
    modport sink   (input valid, input engine_rpm, input road_speed, output ready);
endinterface

interface grc_out_if;
    import grc_pkg::*;
    logic              valid;
    logic              ready;
    logic [GEAR_W-1:0] gear;
    logic              held;
    modport source (output valid, output gear, output held, input ready);
    modport sink   (input valid, input gear, input held, output ready);
endinterface

interface grc_cfg_if;
    import grc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/grc_mul.sv
module grc_mul (
    input  logic                         clk,
    input  grc_pkg::grc_mul_ctrl_t       ctrl,
    output logic [grc_pkg::PROD_W-1:0]   p_reg
);
    import grc_pkg::*;

    logic [PROD_W-1:0] p_next;

    // 16 x 24 unsigned, registered
    assign p_next = ctrl.mul_a * ctrl.mul_b;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_reg <= p_next;
        end
    end

endmodule

### hw/rtl/grc_cfg_regs.sv
module grc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    grc_cfg_if.sink                       cfg_ch,
    input  logic [grc_pkg::GIDX_W-1:0]    sel,
    output logic [grc_pkg::BOUNDS_W-1:0]  sel_bounds,
    output grc_pkg::grc_cfg_t             cfg_vals
);
    import grc_pkg::*;

    logic [BOUNDS_W-1:0] bounds_reg [NUM_BOUND_REGS];
    logic [K_W-1:0]      k_reg;
    logic [RPM_W-1:0]    idle_reg;
    logic [SPEED_W-1:0]  creep_reg;
    logic                wr;

    assign cfg_ch.ready = 1'b1;
    assign wr = cfg_ch.valid && cfg_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOUND_REGS; i++)
            begin
                bounds_reg[i] <= BOUND_RESET[i];
            end
            k_reg     <= K_RESET;
            idle_reg  <= IDLE_RESET;
            creep_reg <= CREEP_RESET;
        end
        else if (wr)
        begin
            if (cfg_ch.index < CFG_IDX_W'(NUM_BOUND_REGS))
            begin
                bounds_reg[cfg_ch.index[GIDX_W-1:0]] <= cfg_ch.data;
            end
            else
            begin
                case (cfg_ch.index)
                    REG_K:     k_reg     <= cfg_ch.data[K_W-1:0];
                    REG_IDLE:  idle_reg  <= cfg_ch.data[RPM_W-1:0];
                    REG_CREEP: creep_reg <= cfg_ch.data[SPEED_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    assign sel_bounds = (sel < GIDX_W'(NUM_BOUND_REGS)) ? bounds_reg[sel] : '0;

    assign cfg_vals.k           = k_reg;
    assign cfg_vals.idle_rpm    = idle_reg;
    assign cfg_vals.creep_speed = creep_reg;

endmodule

### hw/rtl/gear_ratio_classifier.sv
// Gear ratio classifier: estimates the engaged gear from engine rpm and road speed.
// in_ch  : one beat carries engine_rpm (14 b) and road_speed (8 b).
// out_ch : one beat per input beat, gear (0 neutral, 1..min(NUM_GEARS, 5)) and held.
// cfg_ch : index/data write beats, always ready; write only while idle.
//   0..4 gear bounds (min[31:16], max[15:0], Q8.8), 5 drivetrain constant,
//   6 idle rpm threshold, 7 creep speed threshold; other indexes ignored.
// Each gear range is tested as exact cross products rpm*2^16 vs bound*speed*k
// on one shared 16x24 multiplier: the SCALE state for speed*k, then per range
// the LO, HI and CHK states (min product, max product, compare), stopping at
// the first match.
// in_ch.ready is high only while the sequencer is idle, so a new beat is taken
// only after the previous result has moved into the output register.
// A result waiting on a stalled receiver does not block the next input; a
// second result waits in the finish state until the output register frees.
// Reset loads the default register values and clears the previous gear to
// neutral; out_ch.valid drops.
module gear_ratio_classifier #(
    parameter int NUM_GEARS = 5
) (
    input  logic      clk,
    input  logic      rst_n,
    grc_in_if.sink    in_ch,
    grc_out_if.source out_ch,
    grc_cfg_if.sink   cfg_ch
);
    import grc_pkg::*;

    localparam int LIMIT = (NUM_GEARS < NUM_BOUND_REGS) ? NUM_GEARS : NUM_BOUND_REGS;
    localparam logic [GIDX_W-1:0] LAST_IDX = GIDX_W'(LIMIT - 1);

    grc_state_t          state_reg, state_next;
    logic [RPM_W-1:0]    rpm_reg, rpm_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic [GIDX_W-1:0]   gidx_reg, gidx_next;
    logic                ge_reg, ge_next;
    logic [GEAR_W-1:0]   res_gear_reg, res_gear_next;
    logic                res_held_reg, res_held_next;
    logic [GEAR_W-1:0]   prev_gear_reg, prev_gear_next;
    logic                out_valid_reg, out_valid_next;
    logic [GEAR_W-1:0]   out_gear_reg, out_gear_next;
    logic                out_held_reg, out_held_next;

    grc_mul_ctrl_t       mul_ctrl;
    logic [PROD_W-1:0]   prod;
    logic [BOUNDS_W-1:0] sel_bounds;
    grc_cfg_t            cfg_vals;

    logic                in_acc;
    logic                zero_in;
    logic                out_load;
    logic [PROD_W-1:0]   lhs;
    logic                match;
    logic [GEAR_W-1:0]   gear_hit;

    grc_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_ch     (cfg_ch),
        .sel        (gidx_reg),
        .sel_bounds (sel_bounds),
        .cfg_vals   (cfg_vals)
    );

    grc_mul u_mul (
        .clk   (clk),
        .ctrl  (mul_ctrl),
        .p_reg (prod)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign zero_in     = (in_ch.engine_rpm == '0) || (in_ch.road_speed == '0);
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid_reg || out_ch.ready);

    // rpm in Q.16 against bound(Q8.8) * speed * k(Q8.8)
    assign lhs      = PROD_W'({rpm_reg, {FRAC_W{1'b0}}});
    assign match    = ge_reg && (lhs <= prod);
    assign gear_hit = GEAR_W'(gidx_reg) + GEAR_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = zero_in ? ST_FINISH : ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_LO;
            ST_LO:     state_next = ST_HI;
            ST_HI:     state_next = ST_CHK;
            ST_CHK:
            begin
                if (match || (gidx_reg == LAST_IDX))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LO;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // multiplier operands
    always_comb
    begin
        mul_ctrl.mul_en = 1'b0;
        mul_ctrl.mul_a  = '0;
        mul_ctrl.mul_b  = '0;
        case (state_reg)
            ST_SCALE:
            begin
                mul_ctrl.mul_en = 1'b1;
                mul_ctrl.mul_a  = cfg_vals.k;
                mul_ctrl.mul_b  = SCALE_W'(speed_reg);
            end
            ST_LO:
            begin
                // first range: speed*k is still sitting in the product register
                mul_ctrl.mul_en = 1'b1;
                mul_ctrl.mul_a  = sel_bounds[BOUNDS_W-1:BOUND_W];
                mul_ctrl.mul_b  = (gidx_reg == '0) ? prod[SCALE_W-1:0] : scale_reg;
            end
            ST_HI:
            begin
                mul_ctrl.mul_en = 1'b1;
                mul_ctrl.mul_a  = sel_bounds[BOUND_W-1:0];
                mul_ctrl.mul_b  = scale_reg;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        rpm_next       = rpm_reg;
        speed_next     = speed_reg;
        scale_next     = scale_reg;
        gidx_next      = gidx_reg;
        ge_next        = ge_reg;
        res_gear_next  = res_gear_reg;
        res_held_next  = res_held_reg;
        prev_gear_next = prev_gear_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    rpm_next   = in_ch.engine_rpm;
                    speed_next = in_ch.road_speed;
                    gidx_next  = '0;
                    if (zero_in)
                    begin
                        res_gear_next  = GEAR_NONE;
                        res_held_next  = 1'b0;
                        prev_gear_next = GEAR_NONE;
                    end
                end
            end
            ST_LO:
            begin
                if (gidx_reg == '0)
                begin
                    scale_next = prod[SCALE_W-1:0];
                end
            end
            ST_HI:
            begin
                ge_next = (lhs >= prod);
            end
            ST_CHK:
            begin
                if (match)
                begin
                    res_gear_next  = gear_hit;
                    res_held_next  = 1'b0;
                    prev_gear_next = gear_hit;
                end
                else if (gidx_reg == LAST_IDX)
                begin
                    if ((rpm_reg > cfg_vals.idle_rpm) && (speed_reg < cfg_vals.creep_speed))
                    begin
                        res_gear_next  = GEAR_NONE;
                        res_held_next  = 1'b0;
                        prev_gear_next = GEAR_NONE;
                    end
                    else
                    begin
                        res_gear_next = prev_gear_reg;
                        res_held_next = 1'b1;
                    end
                end
                else
                begin
                    gidx_next = gidx_reg + GIDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_gear_next  = out_gear_reg;
        out_held_next  = out_held_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_gear_next  = res_gear_reg;
            out_held_next  = res_held_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gidx_reg      <= '0;
            prev_gear_reg <= GEAR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gidx_reg      <= gidx_next;
            prev_gear_reg <= prev_gear_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpm_reg      <= rpm_next;
        speed_reg    <= speed_next;
        scale_reg    <= scale_next;
        ge_reg       <= ge_next;
        res_gear_reg <= res_gear_next;
        res_held_reg <= res_held_next;
        out_gear_reg <= out_gear_next;
        out_held_reg <= out_held_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.gear  = out_gear_reg;
    assign out_ch.held  = out_held_reg;

`ifndef SYNTHESIS
    // previous gear never names a range beyond those tested
    a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
        prev_gear_reg <= GEAR_W'(LIMIT))
        else $error("previous gear out of range");

    // a zero input skips the range tests
    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && zero_in |=> state_reg == ST_FINISH)
        else $error("zero input did not go straight to finish");

    // range index stays within the tested ranges
    a_gidx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LO || state_reg == ST_HI || state_reg == ST_CHK)
        |-> gidx_reg <= LAST_IDX)
        else $error("range index past last gear");

    // a held result repeats the previous gear
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && res_held_reg |-> res_gear_reg == prev_gear_reg)
        else $error("held result differs from previous gear");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
    import grc_pkg::*;

    // Build-time gear count of the DUT, and the number of ranges it actually walks
    localparam int NUM_GEARS    = 5;
    localparam int GEARS_TESTED = (NUM_GEARS < NUM_BOUND_REGS) ? NUM_GEARS : NUM_BOUND_REGS;

    // Register map entries not covered by the package
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW   = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH  = 4'd15;

    localparam logic [BOUNDS_W-1:0] NEVER_MATCH = 32'hFFFF_0000;  // min > max
    localparam logic [K_W-1:0]      K_UNITY     = 16'd256;        // 1.0 in Q8.8
    localparam logic [K_W-1:0]      K_ZERO      = 16'd0;

    localparam int MAX_GAP         = 18;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 7;
    // Slowest legal beat-to-beat spacing is roughly gap + DUT latency + stall;
    // the watchdog allows many times that.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 60;

    typedef struct packed {
        logic [GEAR_W-1:0] gear;
        logic              held;
    } gear_result_t;

    typedef enum {
        CFG_DEFAULT,
        CFG_REALISTIC,
        CFG_LOW_EXTREME,
        CFG_HIGH_EXTREME,
        CFG_NOISE
    } cfg_flavor_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    grc_in_if  in_ch ();
    grc_out_if out_ch ();
    grc_cfg_if cfg_ch ();

    gear_ratio_classifier #(
        .NUM_GEARS (NUM_GEARS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the register file and the previous-gear state
    // ------------------------------------------------------------------
    logic [BOUNDS_W-1:0] bounds_mdl [NUM_BOUND_REGS];
    logic [K_W-1:0]      k_mdl;
    logic [RPM_W-1:0]    idle_mdl;
    logic [SPEED_W-1:0]  creep_mdl;
    logic [GEAR_W-1:0]   prev_gear_mdl;

    gear_result_t gear_expected [$];   // predicted gear beats, oldest first
    int           err_count    = 0;
    int           quiet_cycles = 0;

    // Idling switches per side; cleared to get back-to-back stretches
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;

    initial
    begin
        for (int g = 0; g < NUM_BOUND_REGS; g++)
        begin
            bounds_mdl[g] = BOUND_RESET[g];
        end
        k_mdl         = K_RESET;
        idle_mdl      = IDLE_RESET;
        creep_mdl     = CREEP_RESET;
        prev_gear_mdl = GEAR_NONE;
    end

    // Gear estimate for one sample. All tests are exact cross products:
    // rpm * 2^16 against bound * speed * k, nothing divided or rounded.
    function automatic gear_result_t classify_gear(input logic [RPM_W-1:0]   rpm,
                                                   input logic [SPEED_W-1:0] speed);
        gear_result_t res;
        logic [63:0]  lhs;
        logic [63:0]  scale;
        logic [63:0]  lo_prod;
        logic [63:0]  hi_prod;
        res.gear = GEAR_NONE;
        res.held = 1'b0;
        // either input at zero: straight to neutral
        if (rpm == '0 || speed == '0)
        begin
            prev_gear_mdl = GEAR_NONE;
            return res;
        end
        lhs   = 64'(rpm) << FRAC_W;
        scale = 64'(speed) * 64'(k_mdl);
        // first matching range wins; an inverted range can never pass both tests
        for (int g = 0; g < GEARS_TESTED; g++)
        begin
            lo_prod = 64'(bounds_mdl[g][BOUNDS_W-1:BOUND_W]) * scale;
            hi_prod = 64'(bounds_mdl[g][BOUND_W-1:0]) * scale;
            if (lhs >= lo_prod && lhs <= hi_prod)
            begin
                prev_gear_mdl = GEAR_W'(g + 1);
                res.gear      = prev_gear_mdl;
                return res;
            end
        end
        // revving near standstill: clutch open
        if (rpm > idle_mdl && speed < creep_mdl)
        begin
            prev_gear_mdl = GEAR_NONE;
            return res;
        end
        // nothing fits: repeat the last gear, flag it
        res.gear = prev_gear_mdl;
        res.held = 1'b1;
        return res;
    endfunction

    function automatic int draw_gap(input bit idling);
        return idling ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one sample beat, prediction taken at acceptance
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [RPM_W-1:0] rpm, input logic [SPEED_W-1:0] speed);
        int gap;
        gap = draw_gap(src_idle);
        repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.engine_rpm <= rpm;
        in_ch.road_speed <= speed;
        do @(posedge clk); while (!in_ch.ready);
        gear_expected.push_back(classify_gear(rpm, speed));
    endtask

    // Sender holds off until every outstanding gear beat has been checked.
    // Every sample yields a beat, so an empty store means the sequencer is idle.
    task automatic wait_results_drained();
        @(negedge clk) in_ch.valid <= 1'b0;
        while (gear_expected.size() != 0) @(posedge clk);
    endtask

    // One register write beat; the shadow copy follows on acceptance
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        if (index < NUM_BOUND_REGS)
            bounds_mdl[index] = data;
        else if (index == REG_K)
            k_mdl = data[K_W-1:0];
        else if (index == REG_IDLE)
            idle_mdl = data[RPM_W-1:0];
        else if (index == REG_CREEP)
            creep_mdl = data[SPEED_W-1:0];
        @(negedge clk) cfg_ch.valid <= 1'b0;
    endtask

    // Writes all eight registers with one kind of setting. Caller drains first.
    task automatic program_flavor(input cfg_flavor_t flavor);
        logic [CFG_DATA_W-1:0] val;
        int unsigned           lo;
        int unsigned           hi;
        for (int g = 0; g < NUM_BOUND_REGS; g++)
        begin
            case (flavor)
                CFG_DEFAULT:      val = BOUND_RESET[g];
                CFG_LOW_EXTREME:  val = (g == 0) ? 32'h0000_FFFF : 32'h0000_0000;
                CFG_HIGH_EXTREME: val = 32'hFFFF_FFFF;
                CFG_NOISE:        val = $urandom();
                default:
                begin
                    // plausible ratio windows between 1.0 and about 28.0
                    lo  = $urandom_range(256, 24 * 256);
                    hi  = lo + $urandom_range(0, 4 * 256);
                    val = {lo[BOUND_W-1:0], hi[BOUND_W-1:0]};
                end
            endcase
            write_reg(REG_BOUNDS_BASE + CFG_IDX_W'(g), val);
        end
        case (flavor)
            CFG_DEFAULT:
            begin
                write_reg(REG_K, CFG_DATA_W'(K_RESET));
                write_reg(REG_IDLE, CFG_DATA_W'(IDLE_RESET));
                write_reg(REG_CREEP, CFG_DATA_W'(CREEP_RESET));
            end
            CFG_LOW_EXTREME:
            begin
                write_reg(REG_K, 32'd1);
                write_reg(REG_IDLE, 32'd0);
                write_reg(REG_CREEP, 32'd0);
            end
            CFG_HIGH_EXTREME:
            begin
                write_reg(REG_K, 32'h0000_FFFF);
                write_reg(REG_IDLE, 32'h0000_3FFF);
                write_reg(REG_CREEP, 32'h0000_00FF);
            end
            CFG_NOISE:
            begin
                // full 32-bit data, upper bits must be dropped
                write_reg(REG_K, $urandom());
                write_reg(REG_IDLE, $urandom());
                write_reg(REG_CREEP, $urandom());
            end
            default:
            begin
                write_reg(REG_K, $urandom_range(200, 3000));
                write_reg(REG_IDLE, $urandom_range(0, 16383));
                write_reg(REG_CREEP, $urandom_range(0, 255));
            end
        endcase
    endtask

    // Random sample, mostly aimed at the configured ratio windows and their edges
    task automatic pick_sample(output logic [RPM_W-1:0] rpm, output logic [SPEED_W-1:0] speed);
        int unsigned mode;
        int unsigned g;
        int unsigned lo;
        int unsigned hi;
        int unsigned b;
        int unsigned est;
        logic [63:0] prod;
        mode  = $urandom_range(0, 99);
        speed = SPEED_W'($urandom_range(1, 255));
        rpm   = RPM_W'($urandom_range(0, 16383));
        if (mode < 55)
        begin
            g  = $urandom_range(0, GEARS_TESTED - 1);
            lo = 32'(bounds_mdl[g][BOUNDS_W-1:BOUND_W]);
            hi = 32'(bounds_mdl[g][BOUND_W-1:0]);
            case ($urandom_range(0, 3))
                0:       b = lo;
                1:       b = hi;
                default: b = $urandom_range(lo, hi);
            endcase
            prod = 64'(b) * 64'(speed) * 64'(k_mdl);
            if ((prod >> FRAC_W) > 64'd16383)
                est = 16383;
            else
                est = 32'(prod >> FRAC_W);
            // nudge across the boundary now and then
            case ($urandom_range(0, 3))
                0:       est = (est < 16383) ? est + 1 : est;
                1:       est = (est > 0) ? est - 1 : est;
                default: est = est;
            endcase
            if (est == 0)
                est = 1;
            rpm = RPM_W'(est);
        end
        else if (mode < 75)
        begin
            speed = SPEED_W'($urandom_range(0, 255));
        end
        else if (mode < 85)
        begin
            if ($urandom_range(0, 1) == 0)
                rpm = '0;
            else
                speed = '0;
        end
        else
        begin
            // around the standstill thresholds
            speed = SPEED_W'($urandom_range(0, 32'(creep_mdl)));
            est   = 32'(idle_mdl) + $urandom_range(0, 4);
            est   = (est >= 2) ? est - 2 : 0;
            rpm   = RPM_W'((est > 16383) ? 16383 : est);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, each gear beat checked against the store
    // ------------------------------------------------------------------
    initial
    begin : gear_checker
        gear_result_t want;
        int           stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(snk_idle);
            repeat (stall) @(negedge clk) out_ch.ready <= 1'b0;
            @(negedge clk) out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            if (gear_expected.size() == 0)
            begin
                $error("gear beat with nothing expected: gear %0d held %0d",
                       out_ch.gear, out_ch.held);
                err_count++;
            end
            else
            begin
                want = gear_expected.pop_front();
                if (out_ch.gear !== want.gear)
                begin
                    $error("gear: expected %0d, actual %0d", want.gear, out_ch.gear);
                    err_count++;
                end
                if (out_ch.held !== want.held)
                begin
                    $error("held: expected %0d, actual %0d", want.held, out_ch.held);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: any beat on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: zero inputs, each default gear, gaps between
    // windows (held), standstill neutral and both sides of the idle threshold.
    task automatic test_reset_defaults();
        send_sample(14'd0, 8'd0);
        send_sample(14'd0, 8'd100);
        send_sample(14'd5000, 8'd0);
        send_sample(14'd16383, 8'd255);
        send_sample(14'd1231, 8'd10);     // ratio ~24   -> gear 1
        send_sample(14'd1333, 8'd20);     // ratio ~13   -> gear 2
        send_sample(14'd1346, 8'd30);     // ratio ~8.75 -> gear 3
        send_sample(14'd1615, 8'd50);     // ratio ~6.3  -> gear 4
        send_sample(14'd2092, 8'd80);     // ratio ~5.1  -> gear 5
        send_sample(14'd2051, 8'd40);     // ratio ~10, between windows: held 5
        send_sample(14'd2000, 8'd3);      // revving at standstill: neutral
        send_sample(14'd500, 8'd3);       // below idle: held neutral
        send_sample(14'd800, 8'd4);       // at idle threshold: held
        send_sample(14'd801, 8'd4);       // just above: neutral
    endtask

    // Unity constant so the ratio is rpm/speed: exact min and max hits,
    // overlapping windows (lower gear wins), inverted windows, zero constant.
    task automatic test_range_edges();
        wait_results_drained();
        write_reg(REG_K, CFG_DATA_W'(K_UNITY));
        write_reg(REG_BOUNDS_BASE + 4'd0, 32'h0A00_1400);   // 10.0 .. 20.0
        write_reg(REG_BOUNDS_BASE + 4'd1, 32'h0500_0A00);   //  5.0 .. 10.0
        write_reg(REG_BOUNDS_BASE + 4'd2, NEVER_MATCH);
        write_reg(REG_BOUNDS_BASE + 4'd3, NEVER_MATCH);
        write_reg(REG_BOUNDS_BASE + 4'd4, NEVER_MATCH);
        write_reg(REG_IDLE, 32'h0000_3FFF);
        send_sample(14'd100, 8'd10);      // on shared edge, gear 1 first
        send_sample(14'd200, 8'd10);      // on max
        send_sample(14'd201, 8'd10);      // just over: held
        send_sample(14'd60, 8'd10);
        send_sample(14'd99, 8'd10);
        send_sample(14'd49, 8'd10);       // under every window: held
        send_sample(14'd50, 8'd10);       // on min of gear 2
        wait_results_drained();
        write_reg(REG_K, CFG_DATA_W'(K_ZERO));
        send_sample(14'd1000, 8'd50);     // max test never passes: held
    endtask

    // Register extremes, then writes to unmapped indexes that must change nothing
    task automatic test_register_extremes();
        wait_results_drained();
        program_flavor(CFG_LOW_EXTREME);
        send_sample(14'd16383, 8'd1);
        send_sample(14'd1, 8'd255);
        wait_results_drained();
        program_flavor(CFG_HIGH_EXTREME);
        send_sample(14'd16383, 8'd1);
        send_sample(14'd9000, 8'd200);
        wait_results_drained();
        write_reg(REG_SPARE_LOW, $urandom());
        write_reg(REG_SPARE_HIGH, $urandom());
        send_sample(14'd3000, 8'd2);
    endtask

    // Phases of random traffic, each under its own register setting
    task automatic test_random_traffic();
        cfg_flavor_t         plan [NUM_PHASES];
        logic [RPM_W-1:0]    rpm;
        logic [SPEED_W-1:0]  speed;
        plan = '{CFG_DEFAULT, CFG_REALISTIC, CFG_LOW_EXTREME, CFG_REALISTIC,
                 CFG_HIGH_EXTREME, CFG_NOISE, CFG_REALISTIC};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_results_drained();
            program_flavor(plan[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 50 == 0)
                begin
                    src_idle = ($urandom_range(0, 3) != 0);
                    snk_idle = ($urandom_range(0, 3) != 0);
                end
                // mid-phase, let the pipe run dry before carrying on
                if (n == ITEMS_PER_PHASE / 2)
                    wait_results_drained();
                pick_sample(rpm, speed);
                send_sample(rpm, speed);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.engine_rpm = '0;
        in_ch.road_speed = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_defaults();
        test_range_edges();
        test_register_extremes();
        test_random_traffic();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

### files.f
hw/rtl/grc_pkg.sv
hw/rtl/grc_ifs.sv
hw/rtl/grc_mul.sv
hw/rtl/grc_cfg_regs.sv
hw/rtl/gear_ratio_classifier.sv
tb/tb_top.sv
